>>> design/hbcd_pkg.sv
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared sizes, opcodes, hash constants and the directory entry layout.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  // sizing
  localparam int ENTRIES = 1024;
  localparam int OWN_W   = 16;
  localparam int ADR_W   = 48;
  localparam int CNT_W   = 32;
  localparam int OP_W    = 3;
  localparam int TOT_W   = 64;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int LNK_W = $clog2(ENTRIES + 1);
  localparam int REM_W = LNK_W;
  localparam int STP_W = $clog2(ENTRIES + 2);
  localparam int GRD_W = $clog2(3 * ENTRIES + 1);
  localparam int DIF_W = (ADR_W > CNT_W) ? ADR_W : CNT_W;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOOKUP    = OP_W'(0);
  localparam logic [OP_W-1:0] OP_INSTALL   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_INV_KEY   = OP_W'(2);
  localparam logic [OP_W-1:0] OP_INV_RANGE = OP_W'(3);
  localparam logic [OP_W-1:0] OP_INV_OWNER = OP_W'(4);
  localparam logic [OP_W-1:0] OP_FLUSH     = OP_W'(5);

  // multiplicative hash
  localparam logic [63:0] MIX_LBA       = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_OWNER     = 64'h00000100000001B3;
  localparam int          HASH_SHIFT_HI = 29;
  localparam int          HASH_SHIFT_LO = 13;
  localparam int          HALF_W        = 24;

  // one directory entry, link holds next index + 1, zero ends the chain
  typedef struct packed {
    logic             valid;
    logic             refd;
    logic             prot;
    logic [OWN_W-1:0] owner;
    logic [ADR_W-1:0] addr;
    logic [LNK_W-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/hbcd_if.sv
// ----------------------------------------------------------------------------
// hbcd_req_if / hbcd_rsp_if
// Valid/ready channels for directory requests and results.
// ----------------------------------------------------------------------------
interface hbcd_req_if import hbcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [OWN_W-1:0] owner;
  logic [ADR_W-1:0] lba;
  logic [CNT_W-1:0] count;

  modport source (output valid, output op, output owner, output lba, output count,
                  input ready);
  modport sink   (input valid, input op, input owner, input lba, input count,
                  output ready);
endinterface

interface hbcd_rsp_if import hbcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [IDX_W-1:0] slot;
  logic             evicted;
  logic             promoted;
  logic [REM_W-1:0] removed_count;
  logic             chain_fault;
  logic [TOT_W-1:0] hits_total;
  logic [TOT_W-1:0] misses_total;

  modport source (output valid, output hit, output slot, output evicted, output promoted,
                  output removed_count, output chain_fault, output hits_total,
                  output misses_total, input ready);
  modport sink   (input valid, input hit, input slot, input evicted, input promoted,
                  input removed_count, input chain_fault, input hits_total,
                  input misses_total, output ready);
endinterface

>>> design/hbcd_ram.sv
// ----------------------------------------------------------------------------
// hbcd_ram
// Generic one-write one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/hbcd_hash.sv
// ----------------------------------------------------------------------------
// hbcd_hash
// Two-stage multiplicative key hash: partial products, then sum and fold.
// ----------------------------------------------------------------------------
module hbcd_hash import hbcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [OWN_W-1:0] own,
  input  logic [ADR_W-1:0] adr,
  output logic             done,
  output logic [IDX_W-1:0] bucket
);

  localparam logic [HALF_W-1:0] M_LO  = MIX_LBA[HALF_W-1:0];
  localparam logic [HALF_W-1:0] M_HI  = MIX_LBA[2*HALF_W-1:HALF_W];
  localparam logic [HALF_W-1:0] OW_LO = MIX_OWNER[HALF_W-1:0];
  localparam logic [HALF_W-1:0] OW_HI = MIX_OWNER[2*HALF_W-1:HALF_W];

  logic [2*HALF_W-1:0] adr_ext;
  logic [31:0]         own_ext;
  logic [2*HALF_W-1:0] p_ll_c, p_lh_c, p_hl_c;
  logic [HALF_W+31:0]  q_l_c, q_h_c;
  logic [2*HALF_W-1:0] p_ll, q_l;
  logic [HALF_W-1:0]   p_lh, p_hl, q_h;
  logic                stage1;
  logic [2*HALF_W-1:0] h;

  // partial products, only the low bits of the 64-bit hash matter
  always_comb begin
    adr_ext = (2*HALF_W)'(adr);
    own_ext = 32'(own);
    p_ll_c  = adr_ext[HALF_W-1:0] * M_LO;
    p_lh_c  = adr_ext[HALF_W-1:0] * M_HI;
    p_hl_c  = adr_ext[2*HALF_W-1:HALF_W] * M_LO;
    q_l_c   = own_ext * OW_LO;
    q_h_c   = own_ext * OW_HI;
  end

  always_ff @(posedge clk) begin
    p_ll <= p_ll_c;
    p_lh <= p_lh_c[HALF_W-1:0];
    p_hl <= p_hl_c[HALF_W-1:0];
    q_l  <= q_l_c[2*HALF_W-1:0];
    q_h  <= q_h_c[HALF_W-1:0];
  end

  // sum and xor-fold into a bucket index
  always_comb begin
    h = p_ll + {p_lh, {HALF_W{1'b0}}} + {p_hl, {HALF_W{1'b0}}} + q_l
        + {q_h, {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    bucket <= (h[HASH_SHIFT_HI +: IDX_W] ^ h[HASH_SHIFT_LO +: IDX_W])
              & IDX_W'(ENTRIES - 1);
  end

  // done flag, registered alongside the hash stages
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

endmodule

>>> design/hashed_block_cache_clock_directory.sv
// ----------------------------------------------------------------------------
// hashed_block_cache_clock_directory
// Hashed tag directory for a sector cache with CLOCK replacement.
// ----------------------------------------------------------------------------
// Handles one request at a time. After reset a clearing pass over all ENTRIES
// (1024) entries and bucket heads runs before the first request is taken.
// Entries live in one RAM and bucket heads in another, both with registered
// reads, so every chain step passes through a read state and a compare state.
// A lookup or key invalidation hashes, reads the head and walks the chain (an
// invalidation hit walks the chain a second time). An install miss steps the
// CLOCK hand, hashes and walks the chain of the victim when it was valid, then
// links the new entry. Range and owner invalidation sweep all entries, plus a
// hash and chain walk per removed entry; flush reads and writes each entry. A
// new request is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module hashed_block_cache_clock_directory import hbcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  hbcd_req_if.sink     req,
  hbcd_rsp_if.source   rsp
);

  typedef enum logic [20:0] {
    S_CLEAR  = 21'h000001,
    S_IDLE   = 21'h000002,
    S_KHASH  = 21'h000004,
    S_UHASH  = 21'h000008,
    S_HREAD  = 21'h000010,
    S_WSTEP  = 21'h000020,
    S_WCMP   = 21'h000040,
    S_UWR    = 21'h000080,
    S_FEND   = 21'h000100,
    S_CLK    = 21'h000200,
    S_CLKCHK = 21'h000400,
    S_VGET   = 21'h000800,
    S_VICT   = 21'h001000,
    S_INSH   = 21'h002000,
    S_INSL   = 21'h004000,
    S_SWRD   = 21'h008000,
    S_SWCHK  = 21'h010000,
    S_SWNEXT = 21'h020000,
    S_FLRD   = 21'h040000,
    S_FLWR   = 21'h080000,
    S_DONE   = 21'h100000
  } state_t;

  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(ENTRIES - 1);

  state_t state;

  // request and result registers
  logic [OP_W-1:0]  op_r;
  logic [OWN_W-1:0] own_r;
  logic [ADR_W-1:0] adr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             hit_r, evicted_r, promoted_r, fault_r;
  logic [IDX_W-1:0] slot_r;
  logic [REM_W-1:0] removed_r;
  logic [TOT_W-1:0] hits, misses;

  // walk, clock and sweep registers
  logic [IDX_W-1:0] key_bkt, walk_bkt;
  logic [LNK_W-1:0] e, prev;
  logic [STP_W-1:0] steps;
  entry_t           prev_word, tgt_word, found_word, vict_word;
  logic [IDX_W-1:0] tgt, found_idx, vict, cur, hand, k;
  logic             found_r, mode_unl;
  logic [GRD_W-1:0] guard;
  logic             rsp_valid;

  // memories
  logic             ent_we, head_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr, head_waddr, head_raddr;
  entry_t           ent_wdata, ent_rdata;
  logic [LNK_W-1:0] head_wdata, head_rdata;
  logic [ENTRY_W-1:0] ent_rdata_raw;

  // hash unit
  logic             hash_start, hash_done;
  logic [OWN_W-1:0] hash_own;
  logic [ADR_W-1:0] hash_adr;
  logic [IDX_W-1:0] hash_bkt;

  // derived values
  logic [IDX_W-1:0] e_idx, hand_inc;
  logic [STP_W-1:0] steps_inc;
  logic             key_match, sweep_match, out_free;
  logic [DIF_W-1:0] addr_diff;

  assign ent_rdata = entry_t'(ent_rdata_raw);

  hbcd_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ENTRY_W'(ent_wdata)),
    .raddr (ent_raddr),
    .rdata (ent_rdata_raw)
  );

  hbcd_ram #(.WIDTH(LNK_W), .DEPTH(ENTRIES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  hbcd_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .own    (hash_own),
    .adr    (hash_adr),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  // helper values
  always_comb begin
    e_idx     = IDX_W'(e - LNK_W'(1));
    steps_inc = steps + STP_W'(1);
    hand_inc  = ((IDX_W+1)'(hand) + (IDX_W+1)'(1) >= (IDX_W+1)'(ENTRIES)) ? '0
                : hand + IDX_W'(1);
    key_match = ent_rdata.valid && (ent_rdata.owner == own_r) && (ent_rdata.addr == adr_r);
    addr_diff = DIF_W'(ent_rdata.addr) - DIF_W'(adr_r);
    sweep_match = ent_rdata.valid && (ent_rdata.owner == own_r)
                  && ((op_r == OP_INV_OWNER)
                      || ((ent_rdata.addr >= adr_r) && (addr_diff < DIF_W'(cnt_r))));
    out_free  = !rsp_valid || rsp.ready;
  end

  // hash start and operand select
  always_comb begin
    hash_start = 1'b0;
    hash_own   = req.owner;
    hash_adr   = req.lba;
    case (state)
      S_IDLE: begin
        hash_start = req.valid && (req.op == OP_LOOKUP || req.op == OP_INSTALL
                                   || req.op == OP_INV_KEY);
      end
      S_VICT: begin
        hash_start = vict_word.valid;
        hash_own   = vict_word.owner;
        hash_adr   = vict_word.addr;
      end
      S_SWCHK: begin
        hash_start = sweep_match;
        hash_own   = ent_rdata.owner;
        hash_adr   = ent_rdata.addr;
      end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = ent_rdata;
    ent_raddr  = '0;
    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    head_raddr = '0;
    case (state)
      S_CLEAR: begin
        ent_we     = 1'b1;
        ent_waddr  = k;
        ent_wdata  = '0;
        head_we    = 1'b1;
        head_waddr = k;
      end
      S_KHASH, S_UHASH: head_raddr = hash_bkt;
      S_WSTEP: ent_raddr = e_idx;
      S_WCMP: begin
        // splice the target out of its chain
        if (mode_unl && e_idx == tgt) begin
          if (prev == '0) begin
            head_we    = 1'b1;
            head_waddr = walk_bkt;
            head_wdata = ent_rdata.link;
          end else begin
            ent_we         = 1'b1;
            ent_waddr      = IDX_W'(prev - LNK_W'(1));
            ent_wdata      = prev_word;
            ent_wdata.link = ent_rdata.link;
          end
        end
      end
      S_UWR: begin
        ent_we          = 1'b1;
        ent_waddr       = tgt;
        ent_wdata       = tgt_word;
        ent_wdata.valid = 1'b0;
      end
      S_FEND: begin
        head_raddr = key_bkt;
        if (op_r == OP_LOOKUP && found_r) begin
          ent_we         = 1'b1;
          ent_waddr      = found_idx;
          ent_wdata      = found_word;
          ent_wdata.refd = 1'b1;
          ent_wdata.prot = found_word.prot | found_word.refd;
        end
      end
      S_CLK: ent_raddr = hand;
      S_CLKCHK: begin
        // second chance: clear reference first, then protect
        if (ent_rdata.valid && (ent_rdata.refd || ent_rdata.prot)) begin
          ent_we    = 1'b1;
          ent_waddr = cur;
          ent_wdata = ent_rdata;
          if (ent_rdata.refd) begin
            ent_wdata.refd = 1'b0;
          end else begin
            ent_wdata.prot = 1'b0;
          end
        end
      end
      S_INSH: head_raddr = key_bkt;
      S_INSL: begin
        ent_we          = 1'b1;
        ent_waddr       = vict;
        ent_wdata.valid = 1'b1;
        ent_wdata.refd  = 1'b0;
        ent_wdata.prot  = 1'b0;
        ent_wdata.owner = own_r;
        ent_wdata.addr  = adr_r;
        ent_wdata.link  = head_rdata;
        head_we         = 1'b1;
        head_waddr      = key_bkt;
        head_wdata      = LNK_W'(vict) + LNK_W'(1);
      end
      S_SWRD, S_FLRD: ent_raddr = k;
      S_FLWR: begin
        ent_we          = 1'b1;
        ent_waddr       = k;
        ent_wdata       = ent_rdata;
        ent_wdata.valid = 1'b0;
        head_we         = 1'b1;
        head_waddr      = k;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      k        <= '0;
      hand     <= '0;
      hits     <= '0;
      misses   <= '0;
      mode_unl <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (k == K_LAST) begin
            state <= S_IDLE;
          end else begin
            k <= k + IDX_W'(1);
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            op_r       <= req.op;
            own_r      <= req.owner;
            adr_r      <= req.lba;
            cnt_r      <= req.count;
            hit_r      <= 1'b0;
            slot_r     <= '0;
            evicted_r  <= 1'b0;
            promoted_r <= 1'b0;
            removed_r  <= '0;
            fault_r    <= 1'b0;
            mode_unl   <= 1'b0;
            k          <= '0;
            case (req.op)
              OP_LOOKUP, OP_INSTALL, OP_INV_KEY: state <= S_KHASH;
              OP_INV_RANGE, OP_INV_OWNER:        state <= S_SWRD;
              OP_FLUSH:                          state <= S_FLRD;
              default:                           state <= S_DONE;
            endcase
          end
        end

        S_KHASH: begin
          if (hash_done) begin
            key_bkt  <= hash_bkt;
            walk_bkt <= hash_bkt;
            state    <= S_HREAD;
          end
        end

        S_UHASH: begin
          if (hash_done) begin
            walk_bkt <= hash_bkt;
            state    <= S_HREAD;
          end
        end

        S_HREAD: begin
          e     <= head_rdata;
          prev  <= '0;
          steps <= '0;
          state <= S_WSTEP;
        end

        // chain step bounds
        S_WSTEP: begin
          if (!mode_unl) begin
            if (e == '0) begin
              found_r <= 1'b0;
              state   <= S_FEND;
            end else if (e > LNK_W'(ENTRIES) || steps_inc > STP_W'(ENTRIES)) begin
              fault_r <= 1'b1;
              found_r <= 1'b0;
              state   <= S_FEND;
            end else begin
              state <= S_WCMP;
            end
          end else begin
            if (e == '0 || e > LNK_W'(ENTRIES) || steps > STP_W'(ENTRIES)) begin
              state <= S_UWR;
            end else begin
              state <= S_WCMP;
            end
          end
        end

        // compare the chain entry
        S_WCMP: begin
          if (!mode_unl && key_match) begin
            found_r    <= 1'b1;
            found_idx  <= e_idx;
            found_word <= ent_rdata;
            state      <= S_FEND;
          end else if (mode_unl && e_idx == tgt) begin
            tgt_word <= '{valid: ent_rdata.valid, refd: ent_rdata.refd,
                          prot: ent_rdata.prot, owner: ent_rdata.owner,
                          addr: ent_rdata.addr, link: '0};
            state    <= S_UWR;
          end else begin
            prev      <= e;
            prev_word <= ent_rdata;
            e         <= ent_rdata.link;
            steps     <= steps_inc;
            state     <= S_WSTEP;
          end
        end

        S_UWR: begin
          mode_unl <= 1'b0;
          case (op_r)
            OP_INSTALL: state <= S_INSH;
            OP_INV_KEY: state <= S_DONE;
            default:    state <= S_SWNEXT;
          endcase
        end

        // act on the key search
        S_FEND: begin
          case (op_r)
            OP_LOOKUP: begin
              if (found_r) begin
                hits       <= hits + TOT_W'(1);
                hit_r      <= 1'b1;
                slot_r     <= found_idx;
                promoted_r <= found_word.refd && !found_word.prot;
              end else begin
                misses <= misses + TOT_W'(1);
              end
              state <= S_DONE;
            end
            OP_INSTALL: begin
              if (found_r) begin
                hit_r  <= 1'b1;
                slot_r <= found_idx;
                state  <= S_DONE;
              end else begin
                guard <= '0;
                state <= S_CLK;
              end
            end
            default: begin
              if (found_r) begin
                hit_r     <= 1'b1;
                slot_r    <= found_idx;
                removed_r <= REM_W'(1);
                tgt       <= found_idx;
                tgt_word  <= found_word;
                walk_bkt  <= key_bkt;
                mode_unl  <= 1'b1;
                state     <= S_HREAD;
              end else begin
                state <= S_DONE;
              end
            end
          endcase
        end

        // clock hand advance
        S_CLK: begin
          if (guard == GRD_W'(3 * ENTRIES)) begin
            vict  <= hand;
            state <= S_VGET;
          end else begin
            cur   <= hand;
            hand  <= hand_inc;
            state <= S_CLKCHK;
          end
        end

        S_CLKCHK: begin
          if (ent_rdata.valid && (ent_rdata.refd || ent_rdata.prot)) begin
            guard <= guard + GRD_W'(1);
            state <= S_CLK;
          end else begin
            vict      <= cur;
            vict_word <= ent_rdata;
            state     <= S_VICT;
          end
        end

        S_VGET: begin
          vict_word <= ent_rdata;
          state     <= S_VICT;
        end

        S_VICT: begin
          if (vict_word.valid) begin
            evicted_r <= 1'b1;
            tgt       <= vict;
            tgt_word  <= vict_word;
            mode_unl  <= 1'b1;
            state     <= S_UHASH;
          end else begin
            state <= S_INSH;
          end
        end

        S_INSH: state <= S_INSL;

        S_INSL: begin
          slot_r <= vict;
          state  <= S_DONE;
        end

        // range and owner sweep
        S_SWRD: state <= S_SWCHK;

        S_SWCHK: begin
          if (sweep_match) begin
            removed_r <= removed_r + REM_W'(1);
            tgt       <= k;
            tgt_word  <= ent_rdata;
            mode_unl  <= 1'b1;
            state     <= S_UHASH;
          end else begin
            state <= S_SWNEXT;
          end
        end

        S_SWNEXT: begin
          if (k == K_LAST) begin
            state <= S_DONE;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_SWRD;
          end
        end

        // flush sweep
        S_FLRD: state <= S_FLWR;

        S_FLWR: begin
          if (ent_rdata.valid) begin
            removed_r <= removed_r + REM_W'(1);
          end
          if (k == K_LAST) begin
            state <= S_DONE;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_FLRD;
          end
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.hit           <= hit_r;
      rsp.slot          <= slot_r;
      rsp.evicted       <= evicted_r;
      rsp.promoted      <= promoted_r;
      rsp.removed_count <= removed_r;
      rsp.chain_fault   <= fault_r;
      rsp.hits_total    <= hits;
      rsp.misses_total  <= misses;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

>>> design/hbcd_check.sv
// ----------------------------------------------------------------------------
// hbcd_check
// Port-level checks on directory results, bound to the top level.
// ----------------------------------------------------------------------------
module hbcd_check import hbcd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             rsp_hit,
  input logic             rsp_evicted,
  input logic             rsp_promoted,
  input logic             rsp_chain_fault,
  input logic [REM_W-1:0] rsp_removed_count
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // an eviction only comes from an install miss
  a_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_evicted |-> !rsp_hit && rsp_removed_count == '0)
    else $error("eviction on a hit");

  // promotion only on a lookup hit
  a_promote: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_promoted |-> rsp_hit && !rsp_evicted)
    else $error("promotion without hit");

  // a broken chain is answered as a miss
  a_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_chain_fault |-> !rsp_hit)
    else $error("hit reported with chain fault");

  // a keyed hit removes at most one entry
  a_remove: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> rsp_removed_count <= REM_W'(1))
    else $error("keyed hit removed several entries");

endmodule

bind hashed_block_cache_clock_directory hbcd_check u_check (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_hit           (rsp.hit),
  .rsp_evicted       (rsp.evicted),
  .rsp_promoted      (rsp.promoted),
  .rsp_chain_fault   (rsp.chain_fault),
  .rsp_removed_count (rsp.removed_count)
);
